// ===== hdl/spq_pkg.sv =====
// package for the sorted priority queue: depth, widths, beat types, codes
// no dependencies
`default_nettype none
package spq_pkg;
	localparam int unsigned QUEUE_DEPTH = 16;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned DATA_W = 32;
	localparam int unsigned PRIO_W = 8;
	localparam int unsigned FILL_W = 5;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP = 1'b1;

	typedef enum logic [1:0] {
		ST_PUSHED = 2'd0,
		ST_POPPED = 2'd1,
		ST_POP_EMPTY = 2'd2,
		ST_PUSH_FULL = 2'd3
	} status_t;

	typedef struct packed {
		logic req_type;
		logic signed [DATA_W-1:0] item_data;
		logic [PRIO_W-1:0] item_priority;
	} req_t;

	typedef struct packed {
		status_t status;
		logic signed [DATA_W-1:0] popped_data;
		logic [PRIO_W-1:0] popped_priority;
		logic [FILL_W-1:0] fill_count;
	} rsp_t;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;
endpackage
`default_nettype wire

// ===== hdl/spq_if.sv =====
// valid/ready channel interfaces for request and response beats
// depends on spq_pkg
`default_nettype none
interface spq_req_if;
	logic valid;
	logic ready;
	spq_pkg::req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface spq_rsp_if;
	logic valid;
	logic ready;
	spq_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/sorted_priority_queue.sv =====
// sorted priority queue top: row of spq_cell slots, count, two-deep response buffer
// depends on spq_pkg, spq_if, spq_cell
// the response beat is registered in out_q, or in skid_q while the output beat stalls
// throughput: one push or pop per cycle while skid_q is empty; every cell compares
// against the new priority in parallel and shifts by one slot in the same cycle
// reset clears the entry count and the response buffer; slot contents are undefined
`default_nettype none
module sorted_priority_queue (
	input wire logic clk,
	input wire logic arst_n,
	spq_req_if.sink req,
	spq_rsp_if.source rsp
);
	localparam int unsigned D = spq_pkg::QUEUE_DEPTH;

	logic [spq_pkg::CNT_W-1:0] count_q;
	logic accept;
	logic full;
	logic empty;
	logic is_pop;
	spq_pkg::cell_ctl_t ctl;
	spq_pkg::entry_t new_ent;
	spq_pkg::entry_t ent [D];
	logic ge [D];
	logic [spq_pkg::CNT_W-1:0] count_nxt;
	spq_pkg::rsp_t res;

	spq_pkg::rsp_t out_q;
	spq_pkg::rsp_t skid_q;
	logic out_vld_q;
	logic skid_vld_q;
	logic take;

	assign req.ready = !skid_vld_q;
	assign accept = req.valid && req.ready;
	assign full = (count_q == spq_pkg::CNT_W'(D));
	assign empty = (count_q == '0);
	assign is_pop = (req.payload.req_type == spq_pkg::REQ_POP);
	assign ctl.push = accept && !is_pop && !full;
	assign ctl.pop = accept && is_pop && !empty;
	assign new_ent.data = req.payload.item_data;
	assign new_ent.prio = req.payload.item_priority;

	for (genvar i = 0; i < D; i++) begin : g_cell
		logic occ;
		logic lge;
		spq_pkg::entry_t lent;
		spq_pkg::entry_t rent;
		assign occ = (spq_pkg::CNT_W'(i) < count_q);
		if (i == 0) begin : g_first
			assign lge = 1'b1;
			assign lent = new_ent;
		end else begin : g_mid
			assign lge = ge[i-1];
			assign lent = ent[i-1];
		end
		if (i == D - 1) begin : g_last
			assign rent = ent[i];
		end else begin : g_inner
			assign rent = ent[i+1];
		end
		spq_cell u_cell (
			.clk(clk),
			.ctl(ctl),
			.occ(occ),
			.left_ge(lge),
			.new_ent(new_ent),
			.left_ent(lent),
			.right_ent(rent),
			.ent(ent[i]),
			.ge(ge[i])
		);
	end

	always_comb begin
		count_nxt = count_q;
		res.popped_data = '0;
		res.popped_priority = '0;
		if (is_pop) begin
			if (empty) begin
				res.status = spq_pkg::ST_POP_EMPTY;
			end else begin
				res.status = spq_pkg::ST_POPPED;
				res.popped_data = ent[0].data;
				res.popped_priority = ent[0].prio;
				count_nxt = count_q - 1'b1;
			end
		end else begin
			if (full) begin
				res.status = spq_pkg::ST_PUSH_FULL;
			end else begin
				res.status = spq_pkg::ST_PUSHED;
				count_nxt = count_q + 1'b1;
			end
		end
		res.fill_count = spq_pkg::FILL_W'(count_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	assign take = out_vld_q && rsp.ready;
	assign rsp.valid = out_vld_q;
	assign rsp.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (take) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= accept;
			end
		end else if (!out_vld_q) begin
			out_vld_q <= accept;
		end else if (accept) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (!out_vld_q) begin
			out_q <= res;
		end else if (accept) begin
			skid_q <= res;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/spq_cell.sv =====
// one slot of the sorted chain: holds an entry, shifts right on insert, left on pop
// depends on spq_pkg
`default_nettype none
module spq_cell (
	input wire logic clk,
	input wire spq_pkg::cell_ctl_t ctl,
	input wire logic occ,
	input wire logic left_ge,
	input wire spq_pkg::entry_t new_ent,
	input wire spq_pkg::entry_t left_ent,
	input wire spq_pkg::entry_t right_ent,
	output spq_pkg::entry_t ent,
	output logic ge
);
	spq_pkg::entry_t ent_q;

	assign ent = ent_q;
	assign ge = occ && (ent_q.prio >= new_ent.prio);

	always_ff @(posedge clk) begin
		if (ctl.push && !ge) begin
			ent_q <= left_ge ? new_ent : left_ent;
		end else if (ctl.pop) begin
			ent_q <= right_ent;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/spq_checker.sv =====
// port-level assertions on the response beats of sorted_priority_queue, plus bind
// depends on spq_pkg, sorted_priority_queue
`default_nettype none
module spq_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire spq_pkg::rsp_t rsp_payload
);
	localparam int unsigned FMAX = (spq_pkg::QUEUE_DEPTH > 31) ? 31 : spq_pkg::QUEUE_DEPTH;
	localparam logic [spq_pkg::FILL_W-1:0] FULL_FILL = spq_pkg::FILL_W'(spq_pkg::QUEUE_DEPTH);

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_payload.fill_count <= spq_pkg::FILL_W'(FMAX))
		else $error("fill count beyond depth");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.status == spq_pkg::ST_POP_EMPTY
		|-> rsp_payload.fill_count == '0)
		else $error("pop on empty with nonzero fill");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.status == spq_pkg::ST_PUSH_FULL
		|-> rsp_payload.fill_count == FULL_FILL)
		else $error("push dropped while not full");

	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.status != spq_pkg::ST_POPPED
		|-> rsp_payload.popped_data == '0 && rsp_payload.popped_priority == '0)
		else $error("popped fields nonzero without a pop");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("stalled response beat changed");
endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_payload(rsp.payload)
);
`default_nettype wire
